// File: rtl/core/pfeval_pkg.sv
`timescale 1ns / 1ps

package pfeval_pkg;

   localparam int STORE_DEPTH_DEF = 64;
   localparam int WORD_W          = 32;
   localparam int NUM_W           = 31;
   localparam int REQ_DATA_W      = 40;
   localparam int REQ_USER_W      = 2;
   localparam int RSP_DATA_W      = 104;

   typedef logic [1:0] action_type;
   localparam action_type ACT_PUSH = 2'd0;
   localparam action_type ACT_OPER = 2'd1;
   localparam action_type ACT_EMIT = 2'd2;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OPC_ADD = 2'd0;
   localparam opcode_type OPC_SUB = 2'd1;
   localparam opcode_type OPC_MUL = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_UNDER = 2'd1;
   localparam status_type ST_OVER  = 2'd2;

   typedef logic [4:0] dp_op_type;
   localparam dp_op_type DP_NOP       = 5'd0;
   localparam dp_op_type DP_LOAD      = 5'd1;
   localparam dp_op_type DP_ERR_OVER  = 5'd2;
   localparam dp_op_type DP_ERR_UNDER = 5'd3;
   localparam dp_op_type DP_PUSH_LF   = 5'd4;
   localparam dp_op_type DP_OP_RD1    = 5'd5;
   localparam dp_op_type DP_OP_RD2    = 5'd6;
   localparam dp_op_type DP_OP_RD3    = 5'd7;
   localparam dp_op_type DP_OP_HR     = 5'd8;
   localparam dp_op_type DP_OP_LW     = 5'd9;
   localparam dp_op_type DP_OP_FW     = 5'd10;
   localparam dp_op_type DP_OP_HV     = 5'd11;
   localparam dp_op_type DP_EM_CLR    = 5'd12;
   localparam dp_op_type DP_EM_RD     = 5'd13;
   localparam dp_op_type DP_EM_LT     = 5'd14;
   localparam dp_op_type DP_EM_OUT    = 5'd15;
   localparam dp_op_type DP_HP_START  = 5'd16;
   localparam dp_op_type DP_HP_LAST   = 5'd17;
   localparam dp_op_type DP_HP_LASTW  = 5'd18;
   localparam dp_op_type DP_HP_CHK    = 5'd19;
   localparam dp_op_type DP_HP_C1     = 5'd20;
   localparam dp_op_type DP_HP_C2     = 5'd21;
   localparam dp_op_type DP_HP_CMP    = 5'd22;
   localparam dp_op_type DP_HP_FIN    = 5'd23;
   localparam dp_op_type DP_HU_START  = 5'd24;
   localparam dp_op_type DP_HU_CHK    = 5'd25;
   localparam dp_op_type DP_HU_CMP    = 5'd26;
   localparam dp_op_type DP_HU_FIN    = 5'd27;

   typedef struct packed {
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       full;
      logic       lt2;
      logic       empty;
      logic       c_end;
      logic       c2_ok;
      logic       stop_pop;
      logic       i_zero;
      logic       stop_push;
      logic       out_busy;
   } dp_status_type;

   function automatic logic [WORD_W-1:0] alu(input logic [WORD_W-1:0] a,
                                             input logic [WORD_W-1:0] b,
                                             input opcode_type op);
      logic [WORD_W-1:0] r;
      unique case (op)
         OPC_ADD: r = a + b;
         OPC_SUB: r = a - b;
         OPC_MUL: r = a * b;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/pfeval_datapath.sv
`timescale 1ns / 1ps

module pfeval_datapath #(
   parameter int STORE_DEPTH = pfeval_pkg::STORE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pfeval_pkg::ctrl_cmd_type          cmd,
   output pfeval_pkg::dp_status_type         sts,
   input  logic [pfeval_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [pfeval_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfeval_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int W  = pfeval_pkg::WORD_W;
   localparam logic [AW:0] DEP = (AW+1)'(STORE_DEPTH);

   function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
      logic [AW:0] r;
      r = (s >= DEP) ? (s - DEP) : s;
      return r[AW-1:0];
   endfunction

   logic [W-1:0] lifo_mem_ff [STORE_DEPTH];
   logic [W-1:0] fifo_mem_ff [STORE_DEPTH];
   logic [W-1:0] heap_mem_ff [STORE_DEPTH];
   logic [W-1:0] lrd_ff, frd_ff, hrd_ff;

   logic [CW-1:0] lcnt_ff, hcnt_ff;
   logic [AW-1:0] head_ff, i_ff, p_ff;
   logic [AW:0]   c_ff;
   logic [1:0]    err_ff;
   logic          emp_ff;
   pfeval_pkg::action_type act_ff;
   pfeval_pkg::opcode_type opc_ff;
   logic [pfeval_pkg::NUM_W-1:0] num_ff;
   logic [W-1:0]  lr_ff, ll_ff, qr_ff, ql_ff, hr_ff, top_ff, last_ff, cval_ff, hval_ff;
   logic          rsp_valid_ff;
   logic [pfeval_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic          l_we, f_we, h_we;
   logic [AW-1:0] l_wa, f_wa, h_wa, l_ra, f_ra, h_ra;
   logic [W-1:0]  l_wd, f_wd, h_wd;
   logic [W-1:0]  alu_a, alu_b, alu_r;
   logic [CW-1:0] lcnt_m1, lcnt_m2;
   logic [AW:0]   cn;
   logic [AW-1:0] pn;
   logic          c_end, c2_ok, stop_pop, stop_push;
   logic [1:0]    emit_status;

   assign lcnt_m1   = lcnt_ff - CW'(1);
   assign lcnt_m2   = lcnt_ff - CW'(2);
   assign cn        = {i_ff, 1'b1};
   assign pn        = (i_ff - AW'(1)) >> 1;
   assign c_end     = {1'b0, cn} >= (AW+2)'(hcnt_ff);
   assign c2_ok     = ((AW+2)'(c_ff) + (AW+2)'(1)) < (AW+2)'(hcnt_ff);
   assign stop_pop  = !($signed(cval_ff) < $signed(last_ff));
   assign stop_push = !($signed(hval_ff) < $signed(hrd_ff));
   assign alu_r     = pfeval_pkg::alu(alu_a, alu_b, opc_ff);
   assign emit_status = (err_ff != pfeval_pkg::ST_OK) ? err_ff :
                        (emp_ff ? pfeval_pkg::ST_UNDER : pfeval_pkg::ST_OK);

   assign sts.action    = act_ff;
   assign sts.full      = lcnt_ff == CW'(STORE_DEPTH);
   assign sts.lt2       = lcnt_ff < CW'(2);
   assign sts.empty     = lcnt_ff == '0;
   assign sts.c_end     = c_end;
   assign sts.c2_ok     = c2_ok;
   assign sts.stop_pop  = stop_pop;
   assign sts.i_zero    = i_ff == '0;
   assign sts.stop_push = stop_push;
   assign sts.out_busy  = rsp_valid_ff;

   always_comb begin
      l_we = 1'b0; f_we = 1'b0; h_we = 1'b0;
      l_wa = lcnt_ff[AW-1:0];
      f_wa = wrap({1'b0, head_ff} + (AW+1)'(lcnt_ff));
      h_wa = i_ff;
      l_wd = {1'b0, num_ff};
      f_wd = {1'b0, num_ff};
      h_wd = last_ff;
      l_ra = lcnt_m1[AW-1:0];
      f_ra = head_ff;
      h_ra = '0;
      alu_a = ll_ff;
      alu_b = lr_ff;
      case (cmd.op)
         pfeval_pkg::DP_PUSH_LF: begin
            l_we = 1'b1;
            f_we = 1'b1;
         end
         pfeval_pkg::DP_OP_RD2: begin
            l_ra = lcnt_m2[AW-1:0];
            f_ra = wrap({1'b0, head_ff} + (AW+1)'(1));
         end
         pfeval_pkg::DP_OP_LW: begin
            l_we = 1'b1;
            l_wa = lcnt_m2[AW-1:0];
            l_wd = alu_r;
         end
         pfeval_pkg::DP_OP_FW: begin
            alu_a = ql_ff;
            alu_b = qr_ff;
            f_we  = 1'b1;
            f_wd  = alu_r;
         end
         pfeval_pkg::DP_OP_HV: begin
            alu_a = top_ff;
            alu_b = hr_ff;
         end
         pfeval_pkg::DP_HP_LAST: h_ra = hcnt_ff[AW-1:0];
         pfeval_pkg::DP_HP_CHK:  h_ra = cn[AW-1:0];
         pfeval_pkg::DP_HP_C1: begin
            h_ra = c_ff[AW-1:0] + AW'(1);
         end
         pfeval_pkg::DP_HP_CMP: begin
            h_we = !stop_pop;
            h_wd = cval_ff;
         end
         pfeval_pkg::DP_HP_FIN: h_we = hcnt_ff != '0;
         pfeval_pkg::DP_HU_CHK: h_ra = pn;
         pfeval_pkg::DP_HU_CMP: begin
            h_we = !stop_push;
            h_wd = hrd_ff;
         end
         pfeval_pkg::DP_HU_FIN: begin
            h_we = 1'b1;
            h_wd = hval_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (l_we) lifo_mem_ff[l_wa] <= l_wd;
      if (f_we) fifo_mem_ff[f_wa] <= f_wd;
      if (h_we) heap_mem_ff[h_wa] <= h_wd;
      lrd_ff <= lifo_mem_ff[l_ra];
      frd_ff <= fifo_mem_ff[f_ra];
      hrd_ff <= heap_mem_ff[h_ra];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         pfeval_pkg::DP_LOAD: begin
            act_ff <= req_tuser;
            num_ff <= req_tdata[pfeval_pkg::NUM_W-1:0];
            opc_ff <= req_tdata[pfeval_pkg::NUM_W+1:pfeval_pkg::NUM_W];
         end
         pfeval_pkg::DP_PUSH_LF: hval_ff <= {1'b0, num_ff};
         pfeval_pkg::DP_OP_RD2: begin
            lr_ff <= lrd_ff;
            qr_ff <= frd_ff;
         end
         pfeval_pkg::DP_OP_RD3: begin
            ll_ff <= lrd_ff;
            ql_ff <= frd_ff;
         end
         pfeval_pkg::DP_OP_HR: hr_ff <= top_ff;
         pfeval_pkg::DP_OP_HV: hval_ff <= alu_r;
         pfeval_pkg::DP_EM_CLR: begin
            lr_ff  <= '0;
            qr_ff  <= '0;
            top_ff <= '0;
            emp_ff <= lcnt_ff == '0;
         end
         pfeval_pkg::DP_EM_LT: begin
            lr_ff <= lrd_ff;
            qr_ff <= frd_ff;
         end
         pfeval_pkg::DP_EM_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_data_ff <= {6'd0, emit_status, top_ff, qr_ff, lr_ff};
            end
         end
         pfeval_pkg::DP_HP_START: i_ff <= '0;
         pfeval_pkg::DP_HP_LAST:  top_ff <= hrd_ff;
         pfeval_pkg::DP_HP_LASTW: last_ff <= hrd_ff;
         pfeval_pkg::DP_HP_CHK:   c_ff <= cn;
         pfeval_pkg::DP_HP_C1:    cval_ff <= hrd_ff;
         pfeval_pkg::DP_HP_C2: begin
            if ($signed(hrd_ff) < $signed(cval_ff)) begin
               cval_ff <= hrd_ff;
               c_ff    <= c_ff + (AW+1)'(1);
            end
         end
         pfeval_pkg::DP_HP_CMP: begin
            if (!stop_pop) i_ff <= c_ff[AW-1:0];
         end
         pfeval_pkg::DP_HU_START: i_ff <= hcnt_ff[AW-1:0];
         pfeval_pkg::DP_HU_CHK:   p_ff <= pn;
         pfeval_pkg::DP_HU_CMP: begin
            if (!stop_push) i_ff <= p_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcnt_ff      <= '0;
         hcnt_ff      <= '0;
         head_ff      <= '0;
         err_ff       <= pfeval_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            pfeval_pkg::DP_ERR_OVER: begin
               if (err_ff == pfeval_pkg::ST_OK) err_ff <= pfeval_pkg::ST_OVER;
            end
            pfeval_pkg::DP_ERR_UNDER: begin
               if (err_ff == pfeval_pkg::ST_OK) err_ff <= pfeval_pkg::ST_UNDER;
            end
            pfeval_pkg::DP_PUSH_LF: lcnt_ff <= lcnt_ff + CW'(1);
            pfeval_pkg::DP_OP_FW: begin
               lcnt_ff <= lcnt_m1;
               head_ff <= wrap({1'b0, head_ff} + (AW+1)'(2));
            end
            pfeval_pkg::DP_EM_LT: begin
               lcnt_ff <= lcnt_m1;
               head_ff <= wrap({1'b0, head_ff} + (AW+1)'(1));
            end
            pfeval_pkg::DP_EM_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  err_ff       <= pfeval_pkg::ST_OK;
               end
            end
            pfeval_pkg::DP_HP_START: hcnt_ff <= hcnt_ff - CW'(1);
            pfeval_pkg::DP_HU_START: hcnt_ff <= hcnt_ff + CW'(1);
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/pfeval_ctrl.sv
`timescale 1ns / 1ps

module pfeval_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  pfeval_pkg::dp_status_type sts,
   output pfeval_pkg::ctrl_cmd_type  cmd
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISP     = 5'd1;
   localparam logic [4:0] S_OP_RD2   = 5'd2;
   localparam logic [4:0] S_OP_RD3   = 5'd3;
   localparam logic [4:0] S_OP_HR    = 5'd4;
   localparam logic [4:0] S_OP_LW    = 5'd5;
   localparam logic [4:0] S_OP_FW    = 5'd6;
   localparam logic [4:0] S_OP_HV    = 5'd7;
   localparam logic [4:0] S_EM_RD    = 5'd8;
   localparam logic [4:0] S_EM_LT    = 5'd9;
   localparam logic [4:0] S_EM_OUT   = 5'd10;
   localparam logic [4:0] S_HP_START = 5'd11;
   localparam logic [4:0] S_HP_LAST  = 5'd12;
   localparam logic [4:0] S_HP_LASTW = 5'd13;
   localparam logic [4:0] S_HP_CHK   = 5'd14;
   localparam logic [4:0] S_HP_C1    = 5'd15;
   localparam logic [4:0] S_HP_C2    = 5'd16;
   localparam logic [4:0] S_HP_CMP   = 5'd17;
   localparam logic [4:0] S_HP_FIN   = 5'd18;
   localparam logic [4:0] S_HU_START = 5'd19;
   localparam logic [4:0] S_HU_CHK   = 5'd20;
   localparam logic [4:0] S_HU_CMP   = 5'd21;
   localparam logic [4:0] S_HU_FIN   = 5'd22;

   logic [4:0] state_ff, state_in, ret_ff, ret_in;

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd.op   = pfeval_pkg::DP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = pfeval_pkg::DP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.action)
               pfeval_pkg::ACT_PUSH: begin
                  if (sts.full) begin
                     cmd.op   = pfeval_pkg::DP_ERR_OVER;
                     state_in = S_IDLE;
                  end else begin
                     cmd.op   = pfeval_pkg::DP_PUSH_LF;
                     state_in = S_HU_START;
                  end
               end
               pfeval_pkg::ACT_OPER: begin
                  if (sts.lt2) begin
                     cmd.op   = pfeval_pkg::DP_ERR_UNDER;
                     state_in = S_IDLE;
                  end else begin
                     cmd.op   = pfeval_pkg::DP_OP_RD1;
                     state_in = S_OP_RD2;
                  end
               end
               pfeval_pkg::ACT_EMIT: begin
                  cmd.op   = pfeval_pkg::DP_EM_CLR;
                  state_in = sts.empty ? S_EM_OUT : S_EM_RD;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_OP_RD2: begin
            cmd.op   = pfeval_pkg::DP_OP_RD2;
            state_in = S_OP_RD3;
         end
         S_OP_RD3: begin
            cmd.op   = pfeval_pkg::DP_OP_RD3;
            state_in = S_HP_START;
            ret_in   = S_OP_HR;
         end
         S_OP_HR: begin
            cmd.op   = pfeval_pkg::DP_OP_HR;
            state_in = S_HP_START;
            ret_in   = S_OP_LW;
         end
         S_OP_LW: begin
            cmd.op   = pfeval_pkg::DP_OP_LW;
            state_in = S_OP_FW;
         end
         S_OP_FW: begin
            cmd.op   = pfeval_pkg::DP_OP_FW;
            state_in = S_OP_HV;
         end
         S_OP_HV: begin
            cmd.op   = pfeval_pkg::DP_OP_HV;
            state_in = S_HU_START;
         end
         S_EM_RD: begin
            cmd.op   = pfeval_pkg::DP_EM_RD;
            state_in = S_EM_LT;
         end
         S_EM_LT: begin
            cmd.op   = pfeval_pkg::DP_EM_LT;
            state_in = S_HP_START;
            ret_in   = S_EM_OUT;
         end
         S_EM_OUT: begin
            cmd.op = pfeval_pkg::DP_EM_OUT;
            if (!sts.out_busy) state_in = S_IDLE;
         end
         S_HP_START: begin
            cmd.op   = pfeval_pkg::DP_HP_START;
            state_in = S_HP_LAST;
         end
         S_HP_LAST: begin
            cmd.op   = pfeval_pkg::DP_HP_LAST;
            state_in = S_HP_LASTW;
         end
         S_HP_LASTW: begin
            cmd.op   = pfeval_pkg::DP_HP_LASTW;
            state_in = S_HP_CHK;
         end
         S_HP_CHK: begin
            cmd.op   = pfeval_pkg::DP_HP_CHK;
            state_in = sts.c_end ? S_HP_FIN : S_HP_C1;
         end
         S_HP_C1: begin
            cmd.op   = pfeval_pkg::DP_HP_C1;
            state_in = sts.c2_ok ? S_HP_C2 : S_HP_CMP;
         end
         S_HP_C2: begin
            cmd.op   = pfeval_pkg::DP_HP_C2;
            state_in = S_HP_CMP;
         end
         S_HP_CMP: begin
            cmd.op   = pfeval_pkg::DP_HP_CMP;
            state_in = sts.stop_pop ? S_HP_FIN : S_HP_CHK;
         end
         S_HP_FIN: begin
            cmd.op   = pfeval_pkg::DP_HP_FIN;
            state_in = ret_ff;
         end
         S_HU_START: begin
            cmd.op   = pfeval_pkg::DP_HU_START;
            state_in = S_HU_CHK;
         end
         S_HU_CHK: begin
            cmd.op   = pfeval_pkg::DP_HU_CHK;
            state_in = sts.i_zero ? S_HU_FIN : S_HU_CMP;
         end
         S_HU_CMP: begin
            cmd.op   = pfeval_pkg::DP_HU_CMP;
            state_in = sts.stop_push ? S_HU_FIN : S_HU_CHK;
         end
         S_HU_FIN: begin
            cmd.op   = pfeval_pkg::DP_HU_FIN;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// File: rtl/core/postfix_stack_queue_heap_evaluator_unit.sv
`timescale 1ns / 1ps
// one item at a time; an entry moves up to log2(STORE_DEPTH) heap levels in a sift
// a push does one heap insertion, an emit one heap removal, an empty-store emit none
// an operator does two heap removals and one heap insertion
// each heap insertion or removal is a sift loop over the heap memory
// a result sits in an output register; pushes and operators go on while it waits, an emit waits
// synchronous active-high reset clears counts, error flag and control; memories are not cleared
module postfix_stack_queue_heap_evaluator_unit #(
   parameter int STORE_DEPTH = pfeval_pkg::STORE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pfeval_pkg::REQ_DATA_W-1:0] req_tdata,  // number, op_code
   input  logic [pfeval_pkg::REQ_USER_W-1:0] req_tuser,  // action
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfeval_pkg::RSP_DATA_W-1:0] rsp_tdata   // stack_top, queue_front, heap_min, status
);

   pfeval_pkg::ctrl_cmd_type  cmd;
   pfeval_pkg::dp_status_type sts;

   pfeval_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pfeval_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("transfer accepted while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[97:96] != 2'd3))
      else $error("bad status code");

   a_count_flags: assert property (@(posedge clock) disable iff (reset)
      !(sts.full && sts.lt2))
      else $error("full and underfilled at once");

endmodule

// File: tb/tb_postfix_stack_queue_heap_evaluator_unit.sv
`timescale 1ns / 1ps

module tb_postfix_stack_queue_heap_evaluator_unit;

   localparam int DEPTH = 64;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int ITEMS_PER_PHASE = 450;
   localparam pfeval_pkg::action_type ACT_NONE = 2'd3;
   localparam pfeval_pkg::opcode_type OPC_ZERO = 2'd3;

   typedef struct packed {
      pfeval_pkg::status_type status;
      logic [31:0]            heap_min;
      logic [31:0]            queue_front;
      logic [31:0]            stack_top;
   } emit_word_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [pfeval_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [pfeval_pkg::REQ_USER_W-1:0] req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [pfeval_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int idle_pct;
   int stall_pct;
   int cycles = 0;

   class evaluator_scoreboard;
      logic [31:0]            lifo[DEPTH];
      logic [31:0]            fifo[DEPTH];
      logic [31:0]            heap[DEPTH];
      int                     lifo_n;
      int                     fifo_hd;
      int                     fifo_n;
      int                     heap_n;
      pfeval_pkg::status_type err;
      emit_word_type          emit_q[$];
      int                     fails;

      function new();
         lifo_n = 0; fifo_hd = 0; fifo_n = 0; heap_n = 0;
         err = pfeval_pkg::ST_OK;
         fails = 0;
      endfunction

      function bit lt(logic [31:0] a, logic [31:0] b);
         return $signed(a) < $signed(b);
      endfunction

      function logic [31:0] calc(logic [31:0] l, logic [31:0] r, pfeval_pkg::opcode_type op);
         case (op)
            pfeval_pkg::OPC_ADD: return l + r;
            pfeval_pkg::OPC_SUB: return l - r;
            pfeval_pkg::OPC_MUL: return l * r;
            default: return '0;
         endcase
      endfunction

      function void flag(pfeval_pkg::status_type code);
         if (err == pfeval_pkg::ST_OK) err = code;
      endfunction

      function logic [31:0] lifo_pop();
         lifo_n--;
         return lifo[lifo_n];
      endfunction

      function logic [31:0] fifo_pop();
         logic [31:0] v;
         v = fifo[fifo_hd];
         fifo_hd = (fifo_hd + 1) % DEPTH;
         fifo_n--;
         return v;
      endfunction

      function void push_all_q(logic [31:0] v);
         fifo[(fifo_hd + fifo_n) % DEPTH] = v;
         fifo_n++;
      endfunction

      function void heap_push(logic [31:0] v);
         int i;
         int p;
         i = heap_n;
         heap_n++;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (!lt(v, heap[p])) break;
            heap[i] = heap[p];
            i = p;
         end
         heap[i] = v;
      endfunction

      function logic [31:0] heap_pop();
         logic [31:0] top;
         logic [31:0] last;
         int i;
         int c;
         top = heap[0];
         heap_n--;
         last = heap[heap_n];
         i = 0;
         forever begin
            c = 2 * i + 1;
            if (c >= heap_n) break;
            if (c + 1 < heap_n && lt(heap[c + 1], heap[c])) c++;
            if (!lt(heap[c], last)) break;
            heap[i] = heap[c];
            i = c;
         end
         if (heap_n > 0) heap[i] = last;
         return top;
      endfunction

      function void note(pfeval_pkg::action_type act, logic [30:0] num,
                         pfeval_pkg::opcode_type op);
         logic [31:0] l;
         logic [31:0] r;
         emit_word_type e;
         bit empty;
         case (act)
            pfeval_pkg::ACT_PUSH: begin
               if (lifo_n >= DEPTH || fifo_n >= DEPTH || heap_n >= DEPTH) begin
                  flag(pfeval_pkg::ST_OVER);
               end else begin
                  lifo[lifo_n] = {1'b0, num};
                  lifo_n++;
                  push_all_q({1'b0, num});
                  heap_push({1'b0, num});
               end
            end
            pfeval_pkg::ACT_OPER: begin
               if (lifo_n < 2 || fifo_n < 2 || heap_n < 2) begin
                  flag(pfeval_pkg::ST_UNDER);
               end else begin
                  r = lifo_pop(); l = lifo_pop();
                  lifo[lifo_n] = calc(l, r, op);
                  lifo_n++;
                  r = fifo_pop(); l = fifo_pop();
                  push_all_q(calc(l, r, op));
                  r = heap_pop(); l = heap_pop();
                  heap_push(calc(l, r, op));
               end
            end
            pfeval_pkg::ACT_EMIT: begin
               e = '0;
               empty = 0;
               e.status = err;
               if (lifo_n > 0) e.stack_top = lifo_pop(); else empty = 1;
               if (fifo_n > 0) e.queue_front = fifo_pop(); else empty = 1;
               if (heap_n > 0) e.heap_min = heap_pop(); else empty = 1;
               if (empty && e.status == pfeval_pkg::ST_OK) e.status = pfeval_pkg::ST_UNDER;
               emit_q.push_back(e);
               err = pfeval_pkg::ST_OK;
            end
            default: ;
         endcase
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
         fails++;
      endtask

      task check(emit_word_type got);
         emit_word_type want;
         if (emit_q.size() == 0) begin
            report("unexpected transfer", got.stack_top, 32'd0);
            return;
         end
         want = emit_q.pop_front();
         if (got.stack_top !== want.stack_top)
            report("stack_top", got.stack_top, want.stack_top);
         if (got.queue_front !== want.queue_front)
            report("queue_front", got.queue_front, want.queue_front);
         if (got.heap_min !== want.heap_min)
            report("heap_min", got.heap_min, want.heap_min);
         if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
      endtask
   endclass

   evaluator_scoreboard sb;

   postfix_stack_queue_heap_evaluator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata[97:0]);
   end

   task send(pfeval_pkg::action_type act, logic [30:0] num, pfeval_pkg::opcode_type op);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, op, num};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      sb.note(act, num, op);
      @(negedge clock);
   endtask

   function logic [30:0] rnd_num();
      case ($urandom_range(0, 3))
         0: return 31'($urandom_range(0, 20));
         1: return 31'h7fffffff - 31'($urandom_range(0, 3));
         default: return 31'($urandom);
      endcase
   endfunction

   task expression(output int n);
      int built;
      int want;
      int k;
      n = 0;
      built = 0;
      want = $urandom_range(1, 6);
      for (k = 0; k < want; k++) begin
         send(pfeval_pkg::ACT_PUSH, rnd_num(), pfeval_pkg::OPC_ADD); n++; built++;
         if (built >= 2 && $urandom_range(0, 1)) begin
            send(pfeval_pkg::ACT_OPER, rnd_num(),
                 pfeval_pkg::opcode_type'($urandom_range(0, 3)));
            n++; built--;
         end
      end
      while (built > 1) begin
         send(pfeval_pkg::ACT_OPER, rnd_num(), pfeval_pkg::opcode_type'($urandom_range(0, 3)));
         n++; built--;
      end
      send(pfeval_pkg::ACT_EMIT, rnd_num(), pfeval_pkg::opcode_type'($urandom_range(0, 3)));
      n++;
   endtask

   task random_phase(int ip, int sp);
      int sent;
      int n;
      int r;
      idle_pct = ip;
      stall_pct = sp;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            while (sb.lifo_n < DEPTH) begin
               send(pfeval_pkg::ACT_PUSH, rnd_num(), pfeval_pkg::OPC_ADD); sent++;
            end
            repeat ($urandom_range(1, 3)) begin
               send(pfeval_pkg::ACT_PUSH, rnd_num(), pfeval_pkg::OPC_ADD); sent++;
            end
         end else if (r < 8) begin
            while (sb.lifo_n > 0) begin
               send(pfeval_pkg::ACT_EMIT, rnd_num(), pfeval_pkg::OPC_ADD); sent++;
            end
            send(pfeval_pkg::ACT_EMIT, rnd_num(), pfeval_pkg::OPC_ADD); sent++;
         end else if (r < 16) begin
            send(pfeval_pkg::action_type'($urandom_range(0, 3)), 31'($urandom),
                 pfeval_pkg::opcode_type'($urandom_range(0, 3)));
            sent++;
         end else begin
            expression(n);
            sent += n;
         end
      end
   endtask

   initial begin
      sb = new();
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty stores, underflow, then sticky error; then each opcode and emits that drain the stores
      send(pfeval_pkg::ACT_EMIT, 31'd0, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_PUSH, 31'h7fffffff, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_OPER, 31'd0, pfeval_pkg::OPC_SUB);
      send(ACT_NONE, 31'h7fffffff, OPC_ZERO);
      send(pfeval_pkg::ACT_EMIT, 31'd0, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_PUSH, 31'h7fffffff, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_PUSH, 31'h7fffffff, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_OPER, 31'h7fffffff, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_PUSH, 31'd0, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_OPER, 31'd0, pfeval_pkg::OPC_SUB);
      send(pfeval_pkg::ACT_PUSH, 31'h7fffffff, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_OPER, 31'd0, pfeval_pkg::OPC_MUL);
      send(pfeval_pkg::ACT_PUSH, 31'd5, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_OPER, 31'd0, OPC_ZERO);
      send(pfeval_pkg::ACT_PUSH, 31'd3, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_PUSH, 31'd9, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_PUSH, 31'd1, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_EMIT, 31'd0, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_EMIT, 31'd0, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_EMIT, 31'd0, pfeval_pkg::OPC_ADD);
      send(pfeval_pkg::ACT_EMIT, 31'd0, pfeval_pkg::OPC_ADD);

      random_phase(0, 0);
      random_phase(72, 0);
      random_phase(0, 72);
      random_phase(35, 35);
      req_tvalid <= 1'b0;

      while (sb.emit_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.fails == 0 && sb.emit_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: postfix_stack_queue_heap_evaluator_unit.f
rtl/core/pfeval_pkg.sv
rtl/core/pfeval_datapath.sv
rtl/core/pfeval_ctrl.sv
rtl/core/postfix_stack_queue_heap_evaluator_unit.sv
tb/tb_postfix_stack_queue_heap_evaluator_unit.sv
